// ===== rtl/lcsr_pkg.sv =====
`default_nettype none

package lcsr_pkg;

	// Geometry of the frame store.
	localparam int LEVELS        = 3;
	localparam int ROWS          = 8;
	localparam int BYTES_PER_ROW = 8;

	localparam int STORE_DEPTH = LEVELS * ROWS * BYTES_PER_ROW;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Field widths fixed by the port list.
	localparam int LVL_W  = 2;
	localparam int ROW_W  = 3;
	localparam int COL_W  = 3;
	localparam int BYTE_W = 8;

	localparam logic [ROW_W-1:0] TOP_ROW  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(BYTES_PER_ROW - 1);
	localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

	// Reset values of the configuration and compare registers.
	localparam logic [BYTE_W-1:0] LEVEL0_ON_RST = 8'd8;
	localparam logic [BYTE_W-1:0] LEVEL1_ON_RST = 8'd8;
	localparam logic [BYTE_W-1:0] LEVEL2_ON_RST = 8'd20;
	localparam logic [BYTE_W-1:0] COMPARE_RST   = 8'h20;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANES_INV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_ON  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_ON  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_ON  = 2'd3;

	// Input item kinds.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Brightness level codes.
	localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
	localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
	localparam logic [LVL_W-1:0] LVL_2 = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} state_t;

	// Linear frame store address of one byte.
	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [LVL_W-1:0] lvl,
		input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col
	);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(lvl) * ADDR_W'(ROWS * BYTES_PER_ROW)
		    + ADDR_W'(row) * ADDR_W'(BYTES_PER_ROW)
		    + ADDR_W'(col);
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/led_cube_scan_refresh.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   mode, wr_level, wr_row, wr_column, wr_value
// out       source     out_valid / out_stall data_byte, plane_restart, plane_bit,
//                                            plane_cleared, on_time, shown_level,
//                                            shown_row, last
// cfg       sink       cfg_we                cfg_index, cfg_data
//
// A write item goes into the store when it is accepted. A tick item is accepted, then
// makes eight reads through the single frame store read port, then drains the read stage.
// Reset clears the 192 entry valid bits at once, so the store reads as zero until
// written; no clearing pass is needed.
// A stall on the output holds the read pipeline; the input stays stalled until the
// last byte of the row sits in the output register.

module led_cube_scan_refresh
	import lcsr_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,

	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  mode,
	input  wire  [LVL_W-1:0]     wr_level,
	input  wire  [ROW_W-1:0]     wr_row,
	input  wire  [COL_W-1:0]     wr_column,
	input  wire  [BYTE_W-1:0]    wr_value,

	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 plane_restart,
	output logic                 plane_bit,
	output logic                 plane_cleared,
	output logic [BYTE_W-1:0]    on_time,
	output logic [LVL_W-1:0]     shown_level,
	output logic [ROW_W-1:0]     shown_row,
	output logic                 last,

	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [BYTE_W-1:0]    cfg_data
);

	state_t state_q, state_nxt;

	logic              planes_inv_q;
	logic [BYTE_W-1:0] level0_on_q, level1_on_q, level2_on_q;
	logic [BYTE_W-1:0] compare_q;
	logic [ROW_W-1:0]  row_q, cur_row_q;
	logic [LVL_W-1:0]  level_q, cur_lvl_q;
	logic              restart_q;
	logic [COL_W-1:0]  col_q;

	logic              in_xfer, tick_xfer, wr_xfer, mem_we;
	logic              rd_en, s1_move;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	logic [BYTE_W-1:0] mem [0:STORE_DEPTH-1];
	logic              vld_q [0:STORE_DEPTH-1];
	logic [BYTE_W-1:0] rdata_s1;
	logic              vld_s1;
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic              out_valid_q;

	// Input transfers.
	assign in_xfer   = in_valid && !in_stall;
	assign tick_xfer = in_xfer && (mode == MODE_TICK);
	assign wr_xfer   = in_xfer && (mode == MODE_WRITE);
	assign mem_we    = wr_xfer && (32'(wr_level) < LEVELS) && (32'(wr_row) < ROWS)
	                   && (32'(wr_column) < BYTES_PER_ROW);
	assign wr_addr   = store_addr(wr_level, wr_row, wr_column);
	assign rd_addr   = store_addr(cur_lvl_q, cur_row_q, col_q);

	// The read stage moves on when the output register is free or being emptied.
	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_inv_q <= 1'b0;
			level0_on_q  <= LEVEL0_ON_RST;
			level1_on_q  <= LEVEL1_ON_RST;
			level2_on_q  <= LEVEL2_ON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLANES_INV: planes_inv_q <= cfg_data[0];
				CFG_LEVEL0_ON:  level0_on_q  <= cfg_data;
				CFG_LEVEL1_ON:  level1_on_q  <= cfg_data;
				CFG_LEVEL2_ON:  level2_on_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row and level scan counters; a tick snapshots the row it shows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= TOP_ROW;
			level_q   <= LVL_0;
			compare_q <= COMPARE_RST;
			cur_row_q <= TOP_ROW;
			cur_lvl_q <= LVL_0;
			restart_q <= 1'b0;
		end else if (tick_xfer) begin
			cur_row_q <= row_q;
			cur_lvl_q <= level_q;
			restart_q <= (row_q == TOP_ROW);
			if (row_q == TOP_ROW) begin
				case (level_q)
					LVL_0:   compare_q <= level0_on_q;
					LVL_1:   compare_q <= level1_on_q;
					LVL_2:   compare_q <= level2_on_q;
					default: ;
				endcase
			end
			if (row_q == '0) begin
				row_q   <= TOP_ROW;
				level_q <= (level_q == LAST_LVL) ? LVL_0 : level_q + 1'b1;
			end else begin
				row_q <= row_q - 1'b1;
			end
		end
	end

	// Scan sequencer: next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (tick_xfer) state_nxt = ST_READ;
			ST_READ:  if (rd_en && col_q == LAST_COL) state_nxt = ST_DRAIN;
			ST_DRAIN: if (s1_move) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Scan sequencer: outputs.
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_READ:  rd_en = !valid_s1 || s1_move;
			ST_DRAIN: ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (tick_xfer) begin
				col_q <= '0;
			end else if (rd_en) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Frame store. Writes happen only while idle and reads only while scanning,
	// so the same entry is never read and written in one cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_value;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
			vld_s1   <= 1'b0;
			valid_s1 <= 1'b0;
			col_s1   <= '0;
		end else begin
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1   <= vld_q[rd_addr];
				col_s1   <= col_q;
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			data_byte     <= vld_s1 ? rdata_s1 : '0;
			plane_restart <= restart_q && (col_s1 == '0);
			plane_bit     <= restart_q && (col_s1 == '0) && !planes_inv_q;
			plane_cleared <= restart_q && (col_s1 == '0) && !planes_inv_q;
			on_time       <= compare_q;
			shown_level   <= cur_lvl_q;
			shown_row     <= cur_row_q;
			last          <= (col_s1 == LAST_COL);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// A read in flight means a scan is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q != ST_IDLE))
		else $error("read stage busy while idle");

	// The store is never written while it is being scanned.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("frame store written during a scan");

	// A plane restart is shown only on the top row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && plane_restart) |-> (shown_row == TOP_ROW))
		else $error("plane restart off the top row");

	// A tick starts the reads in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer |=> (state_q == ST_READ && col_q == '0))
		else $error("tick did not start a row scan");
`endif

endmodule

`default_nettype wire
